[design/ntd_pkg.sv]
// Package with the phase, role and status codes of the tag TLV deframer.
`timescale 1ns / 1ps

package ntd_pkg;

  typedef enum logic [2:0] {
    PH_TYPE     = 3'd0,
    PH_LEN      = 3'd1,
    PH_CTRL_LEN = 3'd2,
    PH_LEN_HI   = 3'd3,
    PH_LEN_LO   = 3'd4,
    PH_VALUE    = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_TYPE  = 3'd0,
    ROLE_SHORT = 3'd1,
    ROLE_HI    = 3'd2,
    ROLE_LO    = 3'd3,
    ROLE_VALUE = 3'd4,
    ROLE_MARK  = 3'd5
  } role_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_BAD_CTRL = 2'd2
  } status_e;

  localparam logic [7:0] TLV_PAD    = 8'h00;
  localparam logic [7:0] TLV_LOCK   = 8'h01;
  localparam logic [7:0] TLV_MEMORY = 8'h02;
  localparam logic [7:0] TLV_NDEF   = 8'h03;
  localparam logic [7:0] TLV_PROP   = 8'hFD;
  localparam logic [7:0] TLV_TERM   = 8'hFE;
  localparam logic [7:0] LEN_MARKER = 8'hFF;
  localparam logic [7:0] CTRL_LEN   = 8'd3;

endpackage

[design/nfc_tag_tlv_deframer_core.sv]
// Top level of the tag TLV deframer: splits tag memory words into TLV blocks.
`timescale 1ns / 1ps

// The deframer takes one byte of tag memory per input word and returns exactly one result
// word for it, naming the role of the byte within its type-length-value block (type,
// short length, long-length marker, length high, length low or value), the block's type
// code, the value length once it is known, and flags for the end of the header and the
// end of the block. NULL and Terminator are one-byte blocks; Lock and Memory Control must
// carry a length of 3, or the byte is flagged and the block abandoned; NDEF and
// Proprietary take a short length or the 0xFF marker and a big-endian 16-bit length.
// Unknown type bytes are flagged and skipped singly. Asserting restart_i with a word makes
// it a fresh type byte whatever block was in progress. The decode of one byte against the
// parse phase is a single level of logic into the result register, so one word is accepted
// per cycle unless the output stalls, and its result appears the cycle after.
// The input is stalled only while a result is held and out_ready_i is low.
module nfc_tag_tlv_deframer_core
  import ntd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  byte_role_o,
  output logic [7:0]  block_type_o,
  output logic [15:0] block_length_o,
  output logic        header_done_o,
  output logic        block_last_o,
  output logic [1:0]  status_o
);

  // Parse state.
  phase_e      phase_q, phase_d;
  logic [7:0]  held_type_q, held_type_d;
  logic [15:0] held_length_q, held_length_d;
  logic [15:0] bytes_left_q, bytes_left_d;

  // Result register.
  logic        out_valid_q;
  role_e       role_q, role_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] length_q, length_d;
  logic        hdr_q, hdr_d;
  logic        last_q, last_d;
  status_e     status_q, status_d;

  logic        accept;
  phase_e      cur_phase;
  logic [15:0] len_lo;
  logic [15:0] left_dec;

  // A new word may enter whenever the result register is empty or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cur_phase = restart_i ? PH_TYPE : phase_q;
  assign len_lo    = {held_length_q[15:8], data_byte_i};
  assign left_dec  = bytes_left_q - 16'd1;

  always_comb begin
    phase_d       = phase_q;
    held_type_d   = held_type_q;
    held_length_d = held_length_q;
    bytes_left_d  = bytes_left_q;
    role_d        = ROLE_TYPE;
    type_d        = held_type_q;
    length_d      = '0;
    hdr_d         = 1'b0;
    last_d        = 1'b0;
    status_d      = ST_OK;
    case (cur_phase)
      PH_LEN: begin
        if (data_byte_i == LEN_MARKER) begin
          role_d  = ROLE_MARK;
          phase_d = PH_LEN_HI;
        end else begin
          role_d        = ROLE_SHORT;
          hdr_d         = 1'b1;
          length_d      = {8'd0, data_byte_i};
          held_length_d = {8'd0, data_byte_i};
          if (data_byte_i == 8'd0) begin
            last_d  = 1'b1;
            phase_d = PH_TYPE;
          end else begin
            bytes_left_d = {8'd0, data_byte_i};
            phase_d      = PH_VALUE;
          end
        end
      end
      PH_CTRL_LEN: begin
        role_d = ROLE_SHORT;
        if (data_byte_i == CTRL_LEN) begin
          hdr_d         = 1'b1;
          length_d      = {8'd0, CTRL_LEN};
          held_length_d = {8'd0, CTRL_LEN};
          bytes_left_d  = {8'd0, CTRL_LEN};
          phase_d       = PH_VALUE;
        end else begin
          status_d      = ST_BAD_CTRL;
          last_d        = 1'b1;
          held_length_d = '0;
          phase_d       = PH_TYPE;
        end
      end
      PH_LEN_HI: begin
        role_d        = ROLE_HI;
        held_length_d = {data_byte_i, 8'd0};
        phase_d       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        role_d        = ROLE_LO;
        hdr_d         = 1'b1;
        length_d      = len_lo;
        held_length_d = len_lo;
        if (len_lo == 16'd0) begin
          last_d  = 1'b1;
          phase_d = PH_TYPE;
        end else begin
          bytes_left_d = len_lo;
          phase_d      = PH_VALUE;
        end
      end
      PH_VALUE: begin
        role_d       = ROLE_VALUE;
        length_d     = held_length_q;
        bytes_left_d = left_dec;
        if (left_dec == 16'd0) begin
          last_d  = 1'b1;
          phase_d = PH_TYPE;
        end
      end
      default: begin
        // Type byte: the block starts afresh.
        role_d        = ROLE_TYPE;
        type_d        = data_byte_i;
        held_type_d   = data_byte_i;
        held_length_d = '0;
        bytes_left_d  = '0;
        if (data_byte_i == TLV_PAD || data_byte_i == TLV_TERM) begin
          hdr_d   = 1'b1;
          last_d  = 1'b1;
          phase_d = PH_TYPE;
        end else if (data_byte_i == TLV_LOCK || data_byte_i == TLV_MEMORY) begin
          phase_d = PH_CTRL_LEN;
        end else if (data_byte_i == TLV_NDEF || data_byte_i == TLV_PROP) begin
          phase_d = PH_LEN;
        end else begin
          status_d = ST_UNKNOWN;
          last_d   = 1'b1;
          phase_d  = PH_TYPE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_TYPE;
      held_type_q   <= '0;
      held_length_q <= '0;
      bytes_left_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        phase_q       <= phase_d;
        held_type_q   <= held_type_d;
        held_length_q <= held_length_d;
        bytes_left_q  <= bytes_left_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      role_q   <= role_d;
      type_q   <= type_d;
      length_q <= length_d;
      hdr_q    <= hdr_d;
      last_q   <= last_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_role_o    = role_q;
  assign block_type_o   = type_q;
  assign block_length_o = length_q;
  assign header_done_o  = hdr_q;
  assign block_last_o   = last_q;
  assign status_o       = status_q;

  // An accepted word always leaves a result behind it.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted word produced no result");

  // While counting value bytes the remaining count is never zero.
  a_value_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_VALUE |-> bytes_left_q != 16'd0)
    else $error("value phase with no bytes left");

  // An error result ends the block and never completes a header.
  a_error_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_OK) |-> (last_q && !hdr_q && length_q == 16'd0))
    else $error("error result with wrong flags");

  // The long-length marker is followed by the length-high phase.
  a_marker_then_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && role_d == ROLE_MARK) |=> phase_q == PH_LEN_HI)
    else $error("marker did not lead to length high");

  // A header ends only on type, short-length or length-low bytes.
  a_header_roles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && hdr_q) |->
      (role_q == ROLE_TYPE || role_q == ROLE_SHORT || role_q == ROLE_LO))
    else $error("header completed on a wrong byte role");

endmodule

[tb/nfc_tag_tlv_deframer_core_test.sv]
// Self-checking testbench for the tag TLV deframer core, with a scoreboard that predicts each word.
`timescale 1ns / 1ps

// Tag memory bytes are fed through the input channel. Each accepted word is decoded by a
// scoreboard that keeps its own copy of the parse state and queues the result it expects.
// Every result word the block hands over is compared field by field with the oldest
// expectation. A short directed opening covers each block type and the awkward cases:
// empty blocks, bad control lengths, the long length form, unknown types and restart.
// The random part is mostly well-formed TLV blocks with random content. Some blocks are
// cut short by restart, and some words are plain noise. It runs through four idling
// phases on the two channels.
module nfc_tag_tlv_deframer_core_test;
  import ntd_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_WORDS = 450;
  localparam int unsigned PRINT_CAP   = 40;

  typedef struct packed {
    role_e       role;
    logic [7:0]  btype;
    logic [15:0] length;
    logic        hdr;
    logic        last;
    status_e     status;
  } tlv_word_t;

  // The scoreboard mirrors the parse state of the deframer and holds the results that are
  // still owed, oldest first.
  class tlv_scoreboard;
    phase_e      parse_phase;
    logic [7:0]  held_type;
    logic [15:0] held_length;
    logic [15:0] bytes_left;
    tlv_word_t   owed_q[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      parse_phase  = PH_TYPE;
      held_type    = 8'h00;
      held_length  = 16'h0000;
      bytes_left   = 16'h0000;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Enters the value part of a block; an empty block ends here, so this returns its
    // end-of-block flag.
    function logic open_value(input logic [15:0] len);
      held_length = len;
      if (len == 16'h0000) begin
        parse_phase = PH_TYPE;
        return 1'b1;
      end
      bytes_left  = len;
      parse_phase = PH_VALUE;
      return 1'b0;
    endfunction

    function void note_byte(input logic [7:0] b, input logic restart);
      tlv_word_t w;
      phase_e    ph;
      w.role   = ROLE_TYPE;
      w.btype  = held_type;
      w.length = 16'h0000;
      w.hdr    = 1'b0;
      w.last   = 1'b0;
      w.status = ST_OK;
      ph = restart ? PH_TYPE : parse_phase;
      case (ph)
        PH_LEN: begin
          if (b == LEN_MARKER) begin
            w.role      = ROLE_MARK;
            parse_phase = PH_LEN_HI;
          end else begin
            w.role   = ROLE_SHORT;
            w.hdr    = 1'b1;
            w.length = {8'h00, b};
            w.last   = open_value({8'h00, b});
          end
        end
        PH_CTRL_LEN: begin
          w.role = ROLE_SHORT;
          if (b == CTRL_LEN) begin
            w.hdr    = 1'b1;
            w.length = {8'h00, CTRL_LEN};
            w.last   = open_value({8'h00, CTRL_LEN});
          end else begin
            w.status    = ST_BAD_CTRL;
            w.last      = 1'b1;
            held_length = 16'h0000;
            parse_phase = PH_TYPE;
          end
        end
        PH_LEN_HI: begin
          w.role      = ROLE_HI;
          held_length = {b, 8'h00};
          parse_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          w.role   = ROLE_LO;
          w.hdr    = 1'b1;
          w.length = {held_length[15:8], b};
          w.last   = open_value({held_length[15:8], b});
        end
        PH_VALUE: begin
          w.role     = ROLE_VALUE;
          w.length   = held_length;
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'h0000) begin
            w.last      = 1'b1;
            parse_phase = PH_TYPE;
          end
        end
        default: begin
          w.btype     = b;
          held_type   = b;
          held_length = 16'h0000;
          bytes_left  = 16'h0000;
          if (b == TLV_PAD || b == TLV_TERM) begin
            w.hdr       = 1'b1;
            w.last      = 1'b1;
            parse_phase = PH_TYPE;
          end else if (b == TLV_LOCK || b == TLV_MEMORY) begin
            parse_phase = PH_CTRL_LEN;
          end else if (b == TLV_NDEF || b == TLV_PROP) begin
            parse_phase = PH_LEN;
          end else begin
            w.status    = ST_UNKNOWN;
            w.last      = 1'b1;
            parse_phase = PH_TYPE;
          end
        end
      endcase
      owed_q.push_back(w);
    endfunction

    task report(input string what);
      if (mismatches < PRINT_CAP) begin
        $display("%0t: result %0d: %s", $realtime, results_seen, what);
      end
      mismatches++;
    endtask

    task check_result(input tlv_word_t got);
      tlv_word_t exp;
      results_seen++;
      if (owed_q.size() == 0) begin
        report("result word with nothing owed");
      end else begin
        exp = owed_q.pop_front();
        if (got.role !== exp.role)
          report($sformatf("byte_role %0d, expected %0d", got.role, exp.role));
        if (got.btype !== exp.btype)
          report($sformatf("block_type %h, expected %h", got.btype, exp.btype));
        if (got.length !== exp.length)
          report($sformatf("block_length %h, expected %h", got.length, exp.length));
        if (got.hdr !== exp.hdr)
          report($sformatf("header_done %b, expected %b", got.hdr, exp.hdr));
        if (got.last !== exp.last)
          report($sformatf("block_last %b, expected %b", got.last, exp.last));
        if (got.status !== exp.status)
          report($sformatf("status %0d, expected %0d", got.status, exp.status));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        restart_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  byte_role_o;
  logic [7:0]  block_type_o;
  logic [15:0] block_length_o;
  logic        header_done_o;
  logic        block_last_o;
  logic [1:0]  status_o;

  tlv_scoreboard sb;
  int unsigned   idle_pct;
  int unsigned   stall_pct;
  int unsigned   words_sent;
  int unsigned   quiet_cycles;
  logic          abandon_pending;

  nfc_tag_tlv_deframer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .byte_role_o    (byte_role_o),
    .block_type_o   (block_type_o),
    .block_length_o (block_length_o),
    .header_done_o  (header_done_o),
    .block_last_o   (block_last_o),
    .status_o       (status_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Both channels are observed at the clock edge, before any register of the block moves.
  // The input word is noted before the output is checked, so the order holds even if a
  // result were to leave in the cycle its byte arrives.
  always @(posedge clk_i) begin
    tlv_word_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_byte(data_byte_i, restart_i);
      end
      if (out_valid_o && out_ready_i) begin
        got.role   = role_e'(byte_role_o);
        got.btype  = block_type_o;
        got.length = block_length_o;
        got.hdr    = header_done_o;
        got.last   = block_last_o;
        got.status = status_e'(status_o);
        sb.check_result(got);
      end
    end
  end

  // Watchdog: a long run of cycles in which neither channel moves a word means the block
  // has hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[nfc_tag_tlv_deframer_core] ERROR");
      $finish;
    end
  end

  // Offers one word and returns at the edge where it is taken. The sender may first sit
  // idle for a random number of cycles.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    restart_i   <= restart;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  // Sends the value part of a block. Now and then it is cut short, and a very long value
  // part is always cut short. The next block then opens with restart.
  task automatic send_values(input int unsigned n);
    int unsigned count;
    count = n;
    if (n > 300) begin
      count = $urandom_range(8);
    end else if (n > 0 && $urandom_range(99) < 8) begin
      count = $urandom_range(n - 1);
    end
    if (count != n) abandon_pending = 1'b1;
    repeat (count) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic send_tlv_block();
    int unsigned kind;
    logic        first_restart;
    logic [7:0]  t;
    logic [7:0]  len_byte;
    logic [7:0]  hi;
    logic [7:0]  lo;
    kind            = $urandom_range(99);
    first_restart   = abandon_pending || ($urandom_range(4) == 0);
    abandon_pending = 1'b0;
    if (kind < 8) begin
      send_byte($urandom_range(1) ? TLV_PAD : TLV_TERM, first_restart);
    end else if (kind < 22) begin
      // Lock or Memory Control; mostly the proper length of three.
      t = $urandom_range(1) ? TLV_LOCK : TLV_MEMORY;
      len_byte = ($urandom_range(99) < 25) ? 8'($urandom_range(255)) : CTRL_LEN;
      send_byte(t, first_restart);
      send_byte(len_byte, 1'b0);
      if (len_byte == CTRL_LEN) send_values(3);
    end else if (kind < 55) begin
      t = $urandom_range(1) ? TLV_NDEF : TLV_PROP;
      len_byte = ($urandom_range(99) < 92) ? 8'($urandom_range(20)) : 8'($urandom_range(254));
      send_byte(t, first_restart);
      send_byte(len_byte, 1'b0);
      send_values(32'(len_byte));
    end else if (kind < 75) begin
      // Long length form; big lengths are abandoned after a few value bytes.
      t = $urandom_range(1) ? TLV_NDEF : TLV_PROP;
      if ($urandom_range(99) < 65) begin
        hi = 8'h00;
        lo = 8'($urandom_range(24));
      end else begin
        hi = 8'($urandom_range(255));
        lo = 8'($urandom_range(255));
      end
      send_byte(t, first_restart);
      send_byte(LEN_MARKER, 1'b0);
      send_byte(hi, 1'b0);
      send_byte(lo, 1'b0);
      send_values(32'({hi, lo}));
    end else if (kind < 85) begin
      t = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(252, 4));
      send_byte(t, first_restart);
    end else begin
      // Noise: raw bytes with restart at random, leaving the parser in any phase.
      repeat ($urandom_range(4, 1)) begin
        send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
      end
      abandon_pending = 1'b1;
    end
  endtask

  initial begin
    sb              = new();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'h00;
    restart_i       = 1'b0;
    out_ready_i     = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    words_sent      = 0;
    quiet_cycles    = 0;
    abandon_pending = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // NULL and Terminator stand alone.
    send_byte(TLV_PAD, 1'b0);
    send_byte(TLV_TERM, 1'b0);
    // Lock Control with its proper length and three value bytes.
    send_byte(TLV_LOCK, 1'b0);
    send_byte(CTRL_LEN, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Memory Control with a wrong length is abandoned.
    send_byte(TLV_MEMORY, 1'b0);
    send_byte(8'h05, 1'b0);
    // An empty NDEF block in the short form.
    send_byte(TLV_NDEF, 1'b0);
    send_byte(8'h00, 1'b0);
    // An empty Proprietary block in the long form.
    send_byte(TLV_PROP, 1'b0);
    send_byte(LEN_MARKER, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // The largest long length, abandoned by a restart on an unknown type byte.
    send_byte(TLV_NDEF, 1'b0);
    send_byte(LEN_MARKER, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Short NDEF block whose value bytes look like a marker and a NULL.
    send_byte(TLV_NDEF, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(LEN_MARKER, 1'b0);
    send_byte(TLV_PAD, 1'b0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      words_sent = 0;
      while (words_sent < PHASE_WORDS) send_tlv_block();
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("[nfc_tag_tlv_deframer_core] OK");
    end else begin
      $display("[nfc_tag_tlv_deframer_core] ERROR");
    end
    $finish;
  end

endmodule
